@@ rtl/aegis_pkg.sv @@
package aegis_pkg;

    localparam int NumWords = 6;

    typedef logic [2:0]   cmd_t;
    typedef logic [127:0] word_t;

    localparam cmd_t CmdEncrypt = 3'd0;
    localparam cmd_t CmdDecrypt = 3'd1;
    localparam cmd_t CmdAbsorb  = 3'd2;
    localparam cmd_t CmdKstream = 3'd3;
    localparam cmd_t CmdKsXor   = 3'd4;
    localparam cmd_t CmdLoad    = 3'd5;
    localparam cmd_t CmdRead    = 3'd6;

    typedef struct packed {
        cmd_t       cmd;
        logic [2:0] word_index;
        word_t      data;
    } item_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
        8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
        8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
        8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
        8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
        8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
        8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
        8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
        8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
        8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
        8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
        8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
        8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
        8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
        8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
        8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
        8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
        8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
        8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
        8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
        8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
        8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
        8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
        8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
        8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
        8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
        8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
        8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
        8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
        8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
        8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
        8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
    };

    function automatic logic [7:0] xtime(input logic [7:0] a);
        xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

endpackage

@@ rtl/aegis_stream_if.sv @@
interface aegis_stream_if #(
    parameter int Width = 8
);
    logic             valid;
    logic             ready;
    logic [Width-1:0] payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/aegis_round.sv @@
// One unkeyed AES round: MixColumns(ShiftRows(SubBytes(x))).
module aegis_round (
    input  aegis_pkg::word_t x,
    output aegis_pkg::word_t y
);
    import aegis_pkg::*;

    logic [7:0] t [16];

    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                t[r + 4*c] = SBOX[x[8*(r + 4*((c + r) % 4)) +: 8]];
            end
        end
        for (int c = 0; c < 4; c++)
        begin
            y[8*(4*c)   +: 8] = xtime(t[4*c]) ^ xtime(t[4*c+1]) ^ t[4*c+1]
                                ^ t[4*c+2] ^ t[4*c+3];
            y[8*(4*c+1) +: 8] = t[4*c] ^ xtime(t[4*c+1]) ^ xtime(t[4*c+2])
                                ^ t[4*c+2] ^ t[4*c+3];
            y[8*(4*c+2) +: 8] = t[4*c] ^ t[4*c+1] ^ xtime(t[4*c+2])
                                ^ xtime(t[4*c+3]) ^ t[4*c+3];
            y[8*(4*c+3) +: 8] = xtime(t[4*c]) ^ t[4*c] ^ t[4*c+1] ^ t[4*c+2]
                                ^ xtime(t[4*c+3]);
        end
    end
endmodule

@@ rtl/aegis_update.sv @@
// State update: six parallel rounds plus message injection into word 0.
module aegis_update (
    input  aegis_pkg::word_t s [aegis_pkg::NumWords],
    input  aegis_pkg::word_t msg,
    output aegis_pkg::word_t ns [aegis_pkg::NumWords]
);
    import aegis_pkg::*;

    word_t r [NumWords];

    for (genvar k = 0; k < NumWords; k++)
    begin : g_rnd
        aegis_round u_round (
            .x (s[(k + NumWords - 1) % NumWords]),
            .y (r[k])
        );
        if (k == 0)
        begin : g_w0
            assign ns[k] = r[k] ^ s[k] ^ msg;
        end
        else
        begin : g_wn
            assign ns[k] = r[k] ^ s[k];
        end
    end
endmodule

@@ rtl/aegis256_block_engine_top.sv @@
// AEGIS-256 block engine. Holds the six 128-bit state words and takes one
// 128-bit block transfer per clock while the output is not stalled. An accepted
// item sits in an input register; from there the keystream S1^S4^S5^(S2&S3) is
// formed, the state is updated by six unkeyed AES rounds in parallel, and any
// result lands in an output register. Throughput is one item per cycle for any
// command mix while the output is not stalled. The state round loop (six rounds
// plus XOR, one level) is the critical path. Absorb, load, unused codes and
// out-of-range loads give no result; a read beyond word five returns zero. The
// input side keeps moving while a result waits, as long as the output register
// is free or being drained in the same cycle.
module aegis256_block_engine_top (
    input logic            clk,
    input logic            rst_n,
    aegis_stream_if.sink   in_ch,
    aegis_stream_if.source out_ch
);
    import aegis_pkg::*;

    item_t item_reg;
    logic  item_vld_reg;
    word_t state_reg [NumWords];
    word_t state_next [NumWords];
    word_t upd [NumWords];
    word_t out_reg, out_next;
    logic  out_vld_reg;
    logic  emit;
    word_t z, o, msg;
    logic  adv;

    // pipeline advances when the output register can take what the
    // input register produces
    assign adv = !out_vld_reg || out_ch.ready;
    assign in_ch.ready = adv;
    assign out_ch.valid = out_vld_reg;
    assign out_ch.payload = out_reg;

    aegis_update u_update (
        .s   (state_reg),
        .msg (msg),
        .ns  (upd)
    );

    always_comb
    begin
        z = state_reg[1] ^ state_reg[4] ^ state_reg[5] ^ (state_reg[2] & state_reg[3]);
        o = (item_reg.cmd == CmdKstream) ? z : (item_reg.data ^ z);
        state_next = state_reg;
        emit = 1'b0;
        out_next = o;
        msg = '0;
        case (item_reg.cmd)
            CmdEncrypt, CmdAbsorb: msg = item_reg.data;
            CmdDecrypt:            msg = o;
            default:               msg = '0;
        endcase
        unique case (item_reg.cmd)
            CmdEncrypt, CmdDecrypt, CmdKstream, CmdKsXor:
            begin
                emit = 1'b1;
                state_next = upd;
            end
            CmdAbsorb:
            begin
                state_next = upd;
            end
            CmdLoad:
            begin
                if (item_reg.word_index < 3'(NumWords))
                begin
                    state_next[item_reg.word_index] = item_reg.data;
                end
            end
            CmdRead:
            begin
                emit = 1'b1;
                out_next = (item_reg.word_index < 3'(NumWords))
                         ? state_reg[item_reg.word_index] : '0;
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
            for (int k = 0; k < NumWords; k++)
            begin
                state_reg[k] <= '0;
            end
        end
        else if (adv)
        begin
            item_vld_reg <= in_ch.valid;
            out_vld_reg  <= item_vld_reg && emit;
            if (item_vld_reg)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            item_reg <= in_ch.payload;
            if (item_vld_reg && emit)
            begin
                out_reg <= out_next;
            end
        end
    end
endmodule

@@ rtl/aegis_checker.sv @@
module aegis_checker (
    input logic   clk,
    input logic   rst_n,
    input logic   in_valid,
    input logic   in_ready,
    input logic   out_valid,
    input logic   out_ready,
    input logic [127:0] out_payload
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_payload))
        else $error("result dropped or changed while stalled");

    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken while output blocked");

    a_no_spont: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_valid && in_ready) && !out_valid |=> ##1 !out_valid || $past(out_valid, 1)
            || $past(in_valid && in_ready, 2))
        else $error("result without input");
endmodule

bind aegis256_block_engine_top aegis_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_payload (out_ch.payload)
);

@@ tb/tb.sv @@
`timescale 1ns / 100ps

module tb;
    import aegis_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    always #4 clk = ~clk;

    // Input payload is the packed item: {cmd, word_index, data}; data[7:0] is byte 0.
    aegis_stream_if #(.Width($bits(item_t))) in_ch ();
    aegis_stream_if #(.Width(128)) out_ch ();

    aegis256_block_engine_top u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .in_ch (in_ch.sink),
        .out_ch(out_ch.source)
    );

    // Own copy of the cipher state; words indexed 0..5, byte 0 in bits 7:0.
    word_t  cipher_words [NumWords] = '{default: '0};
    item_t  pending_items[$];
    word_t  expected_blocks[$];
    int     fail_count = 0;
    int     send_idle_pct = 0;
    int     recv_stall_pct = 0;
    bit     stim_done = 1'b0;

    // ---------------- AES round helpers ----------------
    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] r;
        r = 8'h00;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i])
                r ^= a;
            a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
        end
        return r;
    endfunction

    // S-box computed from the field inverse and the affine map.
    function automatic logic [7:0] sub_byte(input logic [7:0] x);
        logic [7:0] inv;
        logic [7:0] base;
        logic [7:0] s;
        inv = 8'h01;
        base = x;
        for (int e = 0; e < 8; e++)
        begin
            if (8'd254 >> e & 1)
                inv = gf_mul(inv, base);
            base = gf_mul(base, base);
        end
        s = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
            ^ {inv[3:0], inv[7:4]} ^ 8'h63;
        return s;
    endfunction

    function automatic logic [7:0] dbl(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // MixColumns(ShiftRows(SubBytes(blk))) ^ rk
    function automatic word_t aes_round(input word_t blk, input word_t rk);
        logic [7:0] t [16];
        logic [7:0] a0, a1, a2, a3;
        word_t o;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                t[r + 4*c] = sub_byte(blk[8*(r + 4*((c + r) & 3)) +: 8]);
        for (int c = 0; c < 4; c++)
        begin
            a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
            o[8*(4*c)   +: 8] = dbl(a0) ^ dbl(a1) ^ a1 ^ a2 ^ a3;
            o[8*(4*c+1) +: 8] = a0 ^ dbl(a1) ^ dbl(a2) ^ a2 ^ a3;
            o[8*(4*c+2) +: 8] = a0 ^ a1 ^ dbl(a2) ^ dbl(a3) ^ a3;
            o[8*(4*c+3) +: 8] = dbl(a0) ^ a0 ^ a1 ^ a2 ^ dbl(a3);
        end
        return o ^ rk;
    endfunction

    // Apply one item to the state copy; queue its output block if it makes one.
    task automatic predict_block(input item_t it);
        word_t ks, res, msg;
        word_t nxt [NumWords];
        case (it.cmd)
            CmdLoad:
            begin
                if (it.word_index < NumWords)
                    cipher_words[it.word_index] = it.data;
            end
            CmdRead:
                expected_blocks.push_back(it.word_index < NumWords ?
                                          cipher_words[it.word_index] : '0);
            CmdEncrypt, CmdDecrypt, CmdAbsorb, CmdKstream, CmdKsXor:
            begin
                ks = cipher_words[1] ^ cipher_words[4] ^ cipher_words[5]
                     ^ (cipher_words[2] & cipher_words[3]);
                res = (it.cmd == CmdKstream) ? ks : (it.data ^ ks);
                if (it.cmd == CmdEncrypt || it.cmd == CmdAbsorb)
                    msg = it.data;
                else if (it.cmd == CmdDecrypt)
                    msg = res;
                else
                    msg = '0;
                nxt[0] = aes_round(cipher_words[5], cipher_words[0]) ^ msg;
                for (int k = 1; k < NumWords; k++)
                    nxt[k] = aes_round(cipher_words[k-1], cipher_words[k]);
                cipher_words = nxt;
                if (it.cmd != CmdAbsorb)
                    expected_blocks.push_back(res);
            end
            default: ;  // unused code: no effect
        endcase
    endtask

    // ---------------- driver ----------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid   <= 1'b0;
            in_ch.payload <= '0;
        end
        else if (!in_ch.valid || in_ch.ready)
        begin
            // current transfer (if any) completes on this edge
            if (in_ch.valid)
                predict_block(item_t'(in_ch.payload));
            if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                in_ch.valid   <= 1'b1;
                in_ch.payload <= pending_items.pop_front();
            end
            else
                in_ch.valid <= 1'b0;
        end
    end

    // ---------------- monitor / receiver ----------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_blocks.size() == 0)
                begin
                    $display("%0t: unexpected result %h", $time, out_ch.payload);
                    fail_count++;
                end
                else
                begin
                    if (out_ch.payload[63:0] !== expected_blocks[0][63:0])
                    begin
                        $display("%0t: out_lo expected %h actual %h", $time,
                                 expected_blocks[0][63:0], out_ch.payload[63:0]);
                        fail_count++;
                    end
                    if (out_ch.payload[127:64] !== expected_blocks[0][127:64])
                    begin
                        $display("%0t: out_hi expected %h actual %h", $time,
                                 expected_blocks[0][127:64], out_ch.payload[127:64]);
                        fail_count++;
                    end
                    void'(expected_blocks.pop_front());
                end
            end
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ---------------- watchdog ----------------
    int unsigned cycle_count = 0;
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ---------------- stimulus ----------------
    function automatic logic [63:0] rand64();
        case ($urandom_range(5))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic add_item(input cmd_t c, input logic [2:0] idx, input word_t d);
        item_t it;
        it.cmd = c;
        it.word_index = idx;
        it.data = d;
        pending_items.push_back(it);
    endtask

    // Load all six words, run a burst of random-content data blocks, then read a word.
    task automatic add_message();
        int n;
        cmd_t c;
        for (int k = 0; k < NumWords; k++)
            add_item(CmdLoad, 3'(k), {rand64(), rand64()});
        n = $urandom_range(12, 2);
        for (int i = 0; i < n; i++)
        begin
            c = cmd_t'($urandom_range(4));
            add_item(c, 3'($urandom_range(7)), {rand64(), rand64()});
        end
        add_item(CmdRead, 3'($urandom_range(5)), {rand64(), rand64()});
    endtask

    initial
    begin
        int produced;
        repeat (3) @(posedge clk);
        rst_n = 1'b1;

        // directed: every command, data extremes, index edges, unused code
        add_item(CmdRead, 3'd0, '0);
        add_item(CmdKstream, 3'd0, '1);
        add_item(CmdEncrypt, 3'd0, '1);
        add_item(CmdDecrypt, 3'd7, '0);
        add_item(CmdAbsorb, 3'd0, {64'h0123456789abcdef, 64'hfedcba9876543210});
        add_item(CmdKsXor, 3'd0, {64'haaaa5555aaaa5555, 64'h5555aaaa5555aaaa});
        for (int k = 0; k < NumWords; k++)
            add_item(CmdLoad, 3'(k), {64'(k + 1), 64'hffffffff00000000 >> k});
        add_item(CmdLoad, 3'd6, '1);           // out-of-range load ignored
        add_item(CmdLoad, 3'd7, '1);
        add_item(CmdRead, 3'd5, '0);
        add_item(CmdRead, 3'd6, '1);           // out-of-range read gives zero
        add_item(CmdRead, 3'd7, '0);
        add_item(3'd7, 3'd0, '1);              // unused code
        add_item(CmdEncrypt, 3'd5, '0);
        add_item(CmdDecrypt, 3'd0, '1);
        add_item(CmdKstream, 3'd0, '0);
        add_item(CmdRead, 3'd0, '0);

        // four idling phases
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
                default: begin send_idle_pct = 8; recv_stall_pct = 8; end
            endcase
            produced = 0;
            while (produced < 160)
            begin
                if ($urandom_range(9) < 7)
                begin
                    add_message();
                    produced += 14;
                end
                else
                begin
                    add_item(cmd_t'($urandom_range(7)), 3'($urandom_range(7)),
                             {rand64(), rand64()});
                    produced++;
                end
            end
            wait (pending_items.size() == 0 && !in_ch.valid);
            wait (expected_blocks.size() == 0);
        end

        repeat (10) @(posedge clk);
        if (fail_count == 0 && expected_blocks.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule

@@ filelist.f @@
rtl/aegis_pkg.sv
rtl/aegis_stream_if.sv
rtl/aegis_round.sv
rtl/aegis_update.sv
rtl/aegis256_block_engine_top.sv
rtl/aegis_checker.sv
tb/tb.sv
